/* rtl/max_distance_seat_allocator_unit_macros.svh */
// assertion macros used by the checker file
`ifndef MAX_DISTANCE_SEAT_ALLOCATOR_UNIT_MACROS_SVH
`define MAX_DISTANCE_SEAT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MDSA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define MDSA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/mdsa_pkg.sv */
package mdsa_pkg;

    localparam int CFG_W      = 7;
    localparam int OUT_SEAT_W = 6;
    localparam int IN_SEAT_W  = 6;

    localparam logic [CFG_W-1:0] SEAT_COUNT_RESET = 7'd64;

    localparam logic OP_TAKE  = 1'b0;
    localparam logic OP_LEAVE = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEAVE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } mdsa_state_t;

endpackage

/* rtl/max_distance_seat_allocator_unit.sv */
// Max-distance seat allocator. Keeps an occupancy bitmap of a row of seats and serves two
// requests on s_tdata: take (opcode 0) gets the free seat farthest from its nearest neighbor,
// counting end gaps at full length and interior gaps at half length rounded down, lowest seat
// on a tie, seat 0 in an empty room; leave (opcode 1) frees seat_index. Every request gives one
// result beat with the seat and a status (0 ok, 1 room full, 2 seat not occupied or out of
// range). A leave's result is ready the next cycle after the leave is accepted. A take walks the
// bitmap one seat per cycle through a single gap subtract/compare unit; the block takes no new
// request until the walk is over and its result beat is issued. The user must write seat_count
// through cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce this.
// 0 acts as 1, values above MAX_SEATS act as MAX_SEATS, seats at or above the new count are freed.
module max_distance_seat_allocator_unit
    import mdsa_pkg::*;
#(
    parameter int MAX_SEATS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // [0] opcode, [6:1] seat_index, [7] zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,     // [5:0] seat_number, [7:6] status
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int SEAT_W = $clog2(MAX_SEATS);
    localparam int CNT_W  = ($clog2(MAX_SEATS + 1) > CFG_W) ? $clog2(MAX_SEATS + 1) : CFG_W;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] v;
        v = CNT_W'(c);
        if (v == '0) v = CNT_W'(1);
        if (v > CNT_W'(MAX_SEATS)) v = CNT_W'(MAX_SEATS);
        return v;
    endfunction

    mdsa_state_t state_reg, state_next;

    logic [MAX_SEATS-1:0]  occ_reg, occ_next;
    logic [CFG_W-1:0]      seat_count_reg, seat_count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [SEAT_W-1:0]     prev_reg, prev_next;
    logic                  prev_valid_reg, prev_valid_next;
    logic [SEAT_W-1:0]     best_d_reg, best_d_next;
    logic [SEAT_W-1:0]     best_s_reg, best_s_next;
    logic                  best_valid_reg, best_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_SEAT_W-1:0] out_seat_reg, out_seat_next;
    logic [1:0]            out_status_reg, out_status_next;

    logic                 in_op;
    logic [IN_SEAT_W-1:0] in_seat;
    logic                 in_accept;
    logic                 out_free;
    logic [CNT_W-1:0]     eff_count;
    logic [CNT_W-1:0]     wr_eff;
    logic [CNT_W-1:0]     last_idx;
    logic                 leave_ok;

    logic                 taken;
    logic [CNT_W-1:0]     gap_full;
    logic [SEAT_W-1:0]    cand_d;
    logic [SEAT_W-1:0]    cand_s;
    logic [SEAT_W-1:0]    end_d;
    logic [SEAT_W-1:0]    fin_s;
    logic                 fin_valid;

    assign in_op     = s_tdata[0];
    assign in_seat   = s_tdata[IN_SEAT_W:1];
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;
    assign eff_count = clamp_count(seat_count_reg);
    assign wr_eff    = clamp_count(cfg_wr_data);
    assign last_idx  = eff_count - CNT_W'(1);

    assign leave_ok = (CNT_W'(in_seat) < eff_count) ? occ_reg[SEAT_W'(in_seat)] : 1'b0;

    // shared gap unit: one seat per cycle
    assign taken    = occ_reg[idx_reg[SEAT_W-1:0]];
    assign gap_full = (idx_reg - CNT_W'(prev_reg)) >> 1;
    assign cand_d   = prev_valid_reg ? SEAT_W'(gap_full) : idx_reg[SEAT_W-1:0];
    assign cand_s   = prev_valid_reg ? SEAT_W'(prev_reg + SEAT_W'(gap_full)) : '0;

    // right-hand end gap, evaluated once the walk is done
    assign end_d = SEAT_W'(last_idx - CNT_W'(prev_reg));

    always_comb begin
        fin_s     = best_s_reg;
        fin_valid = best_valid_reg;
        if (!prev_valid_reg) begin
            fin_s     = '0;
            fin_valid = 1'b1;
        end else if (end_d > best_d_reg) begin
            fin_s     = last_idx[SEAT_W-1:0];
            fin_valid = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && in_op == OP_TAKE) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (idx_reg == last_idx) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        occ_next        = occ_reg;
        seat_count_next = seat_count_reg;
        idx_next        = idx_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        best_d_next     = best_d_reg;
        best_s_next     = best_s_reg;
        best_valid_next = best_valid_reg;
        out_valid_next  = out_valid_reg;
        out_seat_next   = out_seat_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && m_tready) out_valid_next = 1'b0;

        if (cfg_wr_en) begin
            seat_count_next = cfg_wr_data;
            for (int j = 0; j < MAX_SEATS; j++) begin
                if (CNT_W'(j) >= wr_eff) occ_next[j] = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_op == OP_LEAVE) begin
                        out_valid_next  = 1'b1;
                        out_seat_next   = in_seat;
                        out_status_next = leave_ok ? STATUS_OK : STATUS_BAD_LEAVE;
                        if (leave_ok) occ_next[SEAT_W'(in_seat)] = 1'b0;
                    end else begin
                        idx_next        = '0;
                        prev_valid_next = 1'b0;
                        best_d_next     = '0;
                        best_valid_next = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                idx_next = idx_reg + CNT_W'(1);
                if (taken) begin
                    if (cand_d > best_d_reg) begin
                        best_d_next     = cand_d;
                        best_s_next     = cand_s;
                        best_valid_next = 1'b1;
                    end
                    prev_next       = idx_reg[SEAT_W-1:0];
                    prev_valid_next = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_seat_next   = fin_valid ? OUT_SEAT_W'(fin_s) : '0;
                    out_status_next = fin_valid ? STATUS_OK : STATUS_FULL;
                    if (fin_valid) occ_next[fin_s] = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            seat_count_reg <= SEAT_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            seat_count_reg <= seat_count_next;
            out_valid_reg  <= out_valid_next;
        end
        idx_reg        <= idx_next;
        prev_reg       <= prev_next;
        prev_valid_reg <= prev_valid_next;
        best_d_reg     <= best_d_next;
        best_s_reg     <= best_s_next;
        best_valid_reg <= best_valid_next;
        out_seat_reg   <= out_seat_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_status_reg, out_seat_reg};

endmodule

/* rtl/mdsa_checker.sv */
`include "max_distance_seat_allocator_unit_macros.svh"

module mdsa_checker
    import mdsa_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a take holds the block for the whole walk
    `MDSA_ASSERT_NEXT(a_take_blocks, aclk, aresetn, s_tvalid && s_tready && s_tdata[0] == OP_TAKE, !s_tready)

    // a leave answers on the next cycle and echoes its seat
    `MDSA_ASSERT_NEXT(a_leave_echo, aclk, aresetn, s_tvalid && s_tready && s_tdata[0] == OP_LEAVE, m_tvalid && m_tdata[5:0] == $past(s_tdata[6:1]))

    // a full room reports seat zero
    `MDSA_ASSERT_IMP(a_full_seat_zero, aclk, aresetn, m_tvalid && m_tdata[7:6] == STATUS_FULL, m_tdata[5:0] == 6'd0)

    // a stalled result beat holds
    `MDSA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind max_distance_seat_allocator_unit mdsa_checker u_mdsa_checker (.*);

/* dv/max_distance_seat_allocator_unit_tb.sv */
module max_distance_seat_allocator_unit_tb;
    import mdsa_pkg::*;

    localparam int ROW_SEATS     = 64;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic [OUT_SEAT_W-1:0] seat;
        logic [1:0]            status;
    } seat_result_t;

    class seat_map_scoreboard;
        logic [ROW_SEATS-1:0] occ_map;
        logic [CFG_W-1:0]     seat_cnt;
        seat_result_t         expected_q[$];

        function new();
            occ_map  = '0;
            seat_cnt = SEAT_COUNT_RESET;
        endfunction

        // 0 acts as 1, anything above the row width acts as the full row
        function int seats_in_use();
            if (seat_cnt == 0) return 1;
            if (int'(seat_cnt) > ROW_SEATS) return ROW_SEATS;
            return int'(seat_cnt);
        endfunction

        function void apply_seat_count(logic [CFG_W-1:0] value);
            int n;
            seat_cnt = value;
            n = seats_in_use();
            for (int i = n; i < ROW_SEATS; i++) occ_map[i] = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int random_occupied();
            int n;
            int start;
            int s;
            n = seats_in_use();
            start = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++) begin
                s = (start + i) % n;
                if (occ_map[s]) return s;
            end
            return -1;
        endfunction

        function void note_request(logic op, logic [IN_SEAT_W-1:0] idx);
            seat_result_t res;
            int n;
            int prev;
            int best_d;
            int best_s;
            int d;
            n = seats_in_use();
            if (op == OP_LEAVE) begin
                res.seat = idx;
                if (int'(idx) >= n || !occ_map[idx]) begin
                    res.status = STATUS_BAD_LEAVE;
                end else begin
                    occ_map[idx] = 1'b0;
                    res.status = STATUS_OK;
                end
            end else begin
                prev   = -1;
                best_d = 0;
                best_s = -1;
                for (int i = 0; i < n; i++) begin
                    if (occ_map[i]) begin
                        if (prev < 0) begin
                            // left wall gap counts at full length
                            if (i > best_d) begin
                                best_d = i;
                                best_s = 0;
                            end
                        end else begin
                            d = (i - prev) / 2;
                            if (d > best_d) begin
                                best_d = d;
                                best_s = prev + d;
                            end
                        end
                        prev = i;
                    end
                end
                if (prev < 0) begin
                    best_s = 0;
                end else if (n - 1 - prev > best_d) begin
                    best_s = n - 1;
                end
                if (best_s < 0) begin
                    res.seat   = '0;
                    res.status = STATUS_FULL;
                end else begin
                    occ_map[best_s] = 1'b1;
                    res.seat   = OUT_SEAT_W'(best_s);
                    res.status = STATUS_OK;
                end
            end
            expected_q.push_back(res);
        endfunction

        // empty string when the beat matches the oldest expectation
        function string check_result(logic [OUT_SEAT_W-1:0] seat, logic [1:0] status);
            seat_result_t want;
            string msg;
            msg = "";
            if (expected_q.size() == 0)
                return $sformatf("result beat with nothing pending: seat %0d status %0d",
                                 seat, status);
            want = expected_q.pop_front();
            if (seat !== want.seat)
                msg = $sformatf("seat_number %0d, wanted %0d", seat, want.seat);
            if (status !== want.status)
                msg = {msg, (msg == "") ? "" : "; ",
                       $sformatf("status %0d, wanted %0d", status, want.status)};
            return msg;
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    seat_map_scoreboard sb;
    int  errors = 0;
    int  items_sent = 0;
    int  stall_cycles = 0;
    bit  idle_s = 1'b0;
    bit  idle_m = 1'b0;

    max_distance_seat_allocator_unit #(
        .MAX_SEATS(ROW_SEATS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // one request beat; returns at the edge that accepted it
    task automatic send_request(logic op, logic [IN_SEAT_W-1:0] idx);
        int gap;
        gap = idle_s ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, idx, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, idx);
        items_sent++;
    endtask

    // drain every outstanding result, then write the count while the block is idle
    task automatic write_seat_count(logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.apply_seat_count(value);
        cfg_wr_en <= 1'b0;
    endtask

    // result side
    initial begin
        int gap;
        string msg;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = idle_m ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            msg = sb.check_result(m_tdata[5:0], m_tdata[7:6]);
            if (msg != "") report_mismatch(msg);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL max_distance_seat_allocator_unit");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int phase_len;
        int take_pct;
        int roll;
        int seat;
        int random_start;
        logic [CFG_W-1:0] cnt;

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full row: empty room, far wall, middle split, leave and double leave
        send_request(OP_TAKE, 6'h3F);
        send_request(OP_TAKE, 6'h00);
        send_request(OP_TAKE, 6'h2A);
        send_request(OP_LEAVE, 6'd31);
        send_request(OP_LEAVE, 6'd31);
        send_request(OP_TAKE, 6'h15);
        send_request(OP_LEAVE, 6'd0);
        send_request(OP_TAKE, 6'h00);
        send_request(OP_LEAVE, 6'd62);

        // shrink while occupied: upper seats get freed
        write_seat_count(7'd2);
        send_request(OP_TAKE, 6'h3F);
        send_request(OP_TAKE, 6'h00);
        send_request(OP_LEAVE, 6'd1);
        send_request(OP_LEAVE, 6'd63);

        // zero acts as a single seat
        write_seat_count(7'd0);
        send_request(OP_TAKE, 6'h00);
        send_request(OP_TAKE, 6'h3F);
        send_request(OP_LEAVE, 6'd1);
        send_request(OP_LEAVE, 6'd0);

        // oversize count clamps to the full row
        write_seat_count(7'd127);
        send_request(OP_TAKE, 6'h00);
        send_request(OP_TAKE, 6'h00);
        send_request(OP_TAKE, 6'h00);
        send_request(OP_LEAVE, 6'd63);
        send_request(OP_LEAVE, 6'd0);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       cnt = 7'd64;
                1:       cnt = 7'd1;
                2:       cnt = 7'd0;
                3:       cnt = 7'd127;
                4:       cnt = 7'($urandom_range(65, 127));
                5, 6:    cnt = 7'($urandom_range(2, 12));
                default: cnt = 7'($urandom_range(1, 64));
            endcase
            write_seat_count(cnt);
            idle_s = ($urandom_range(0, 3) == 0);
            idle_m = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 120);
            take_pct  = $urandom_range(40, 85);
            for (int k = 0; k < phase_len; k++) begin
                roll = $urandom_range(0, 99);
                seat = sb.random_occupied();
                if (roll < take_pct || (roll < 92 && seat < 0)) begin
                    // seat_index is don't-care on a take, so keep it noisy
                    send_request(OP_TAKE, 6'($urandom));
                end else if (roll < 92) begin
                    send_request(OP_LEAVE, 6'(seat));
                end else begin
                    send_request(OP_LEAVE, 6'($urandom));
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS max_distance_seat_allocator_unit");
        end else begin
            $display("FAIL max_distance_seat_allocator_unit");
        end
        $finish;
    end

endmodule
